// File: src/sapi_pkg.sv
// Shared types, byte codes and status codes for the serial API frame receiver.
// Used by sapi_decode and serial_api_frame_receiver; depends on nothing.

package sapi_pkg;

	// Protocol bytes
	localparam logic [7:0] SOF_BYTE = 8'h01;
	localparam logic [7:0] ACK_BYTE = 8'h06;
	localparam logic [7:0] NAK_BYTE = 8'h15;
	localparam logic [7:0] CAN_BYTE = 8'h18;
	localparam logic [7:0] XOR_SEED = 8'hFF;

	// Reset value of the length limit register
	localparam logic [7:0] MAX_LEN_RESET = 8'd64;

	// Smallest legal length byte: one payload byte plus the checksum
	localparam logic [7:0] MIN_LEN = 8'd2;

	// Item operations
	localparam logic OP_BYTE    = 1'b0;
	localparam logic OP_TIMEOUT = 1'b1;

	// Receive phases
	localparam logic [1:0] PH_HUNT = 2'd0;
	localparam logic [1:0] PH_LEN  = 2'd1;
	localparam logic [1:0] PH_BODY = 2'd2;
	localparam logic [1:0] PH_CK   = 2'd3;

	// Result status codes
	localparam logic [1:0] ST_BODY    = 2'd0;
	localparam logic [1:0] ST_END_OK  = 2'd1;
	localparam logic [1:0] ST_END_BAD = 2'd2;
	localparam logic [1:0] ST_TIMEOUT = 2'd3;

	// Frame tracking state
	typedef struct packed {
		logic [1:0] phase;
		logic [7:0] length_byte;
		logic [7:0] body_count;
		logic [7:0] running_xor;
		logic       ack_flag;
	} rx_state_t;

	// One result transaction
	typedef struct packed {
		logic [1:0] status;
		logic [7:0] data;
		logic [7:0] index;
		logic [7:0] frame_len;
		logic       ack_seen;
		logic       send_ack;
	} rx_result_t;

	localparam rx_state_t STATE_RESET = '{
		phase:       PH_HUNT,
		length_byte: 8'd0,
		body_count:  8'd0,
		running_xor: XOR_SEED,
		ack_flag:    1'b0
	};

endpackage

// File: src/sapi_decode.sv
// Next-state and result logic for one received byte or timeout tick.
// Purely combinational; uses types and codes from sapi_pkg.

module sapi_decode (
	input  sapi_pkg::rx_state_t  cur,
	input  logic                 op,
	input  logic [7:0]           rx_byte,
	input  logic [7:0]           max_len,
	output sapi_pkg::rx_state_t  nxt,
	output logic                 res_valid,
	output sapi_pkg::rx_result_t res
);

	logic [7:0] body_next;
	logic [7:0] len_minus1;

	assign body_next  = cur.body_count + 8'd1;
	assign len_minus1 = cur.length_byte - 8'd1;

	// Advance the frame state and build the result for this item
	always_comb begin
		nxt           = cur;
		res_valid     = 1'b0;
		res.status    = sapi_pkg::ST_BODY;
		res.data      = 8'd0;
		res.index     = 8'd0;
		res.frame_len = 8'd0;
		res.ack_seen  = cur.ack_flag;
		res.send_ack  = 1'b0;

		if (op == sapi_pkg::OP_TIMEOUT) begin
			// Abort any frame and report the timeout
			res_valid  = 1'b1;
			res.status = sapi_pkg::ST_TIMEOUT;
			nxt        = sapi_pkg::STATE_RESET;
		end else begin
			unique case (cur.phase)
				sapi_pkg::PH_HUNT: begin
					// Note ACK, wait for SOF, drop anything else
					if (rx_byte == sapi_pkg::ACK_BYTE) begin
						nxt.ack_flag = 1'b1;
					end else if (rx_byte == sapi_pkg::SOF_BYTE) begin
						nxt.phase = sapi_pkg::PH_LEN;
					end
				end
				sapi_pkg::PH_LEN: begin
					// Reject out-of-range length, else seed the checksum
					if (rx_byte < sapi_pkg::MIN_LEN || rx_byte > max_len) begin
						nxt.phase = sapi_pkg::PH_HUNT;
					end else begin
						nxt.phase       = sapi_pkg::PH_BODY;
						nxt.length_byte = rx_byte;
						nxt.body_count  = 8'd0;
						nxt.running_xor = sapi_pkg::XOR_SEED ^ rx_byte;
					end
				end
				sapi_pkg::PH_BODY: begin
					// Emit the body byte and fold it into the checksum
					res_valid       = 1'b1;
					res.data        = rx_byte;
					res.index       = cur.body_count;
					nxt.running_xor = cur.running_xor ^ rx_byte;
					nxt.body_count  = body_next;
					if (body_next >= len_minus1) begin
						nxt.phase = sapi_pkg::PH_CK;
					end
				end
				sapi_pkg::PH_CK: begin
					// Close the frame with a verdict and an ACK request
					res_valid     = 1'b1;
					res.status    = (rx_byte == cur.running_xor) ?
						sapi_pkg::ST_END_OK : sapi_pkg::ST_END_BAD;
					res.frame_len = len_minus1;
					res.send_ack  = 1'b1;
					nxt           = sapi_pkg::STATE_RESET;
				end
				default: begin
					nxt = cur;
				end
			endcase
		end
	end

endmodule

// File: src/serial_api_frame_receiver.sv
// Top level of the serial API frame receiver: input stage, frame state and
// result register around sapi_decode. Depends on sapi_pkg and sapi_decode.

// Takes one transaction per cycle while out_ready keeps up: a received UART
// byte (op 0) or a read timeout tick (op 1). Each transaction passes an
// input register, then the frame state update and result build in
// sapi_decode, then the result register that drives out_valid. A new
// transaction can enter every cycle as long as out_ready keeps up; the
// result register is the only place a stall can back up from. Hunting bytes
// and the length byte produce no result. Body bytes come out with their
// index, the checksum byte yields a good or bad frame-end result with
// send_ack set, and a timeout yields a timeout result in any phase. The
// max_len register resets to 64 and is written through cfg_we/cfg_wdata;
// the user must write it only while idle; the block does not enforce this.

module serial_api_frame_receiver (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       op,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] status,
	output logic [7:0] data,
	output logic [7:0] index,
	output logic [7:0] frame_len,
	output logic       ack_seen,
	output logic       send_ack
);

	logic                 valid_s1;
	logic                 op_s1;
	logic [7:0]           byte_s1;
	logic [7:0]           max_len_q;
	sapi_pkg::rx_state_t  state_q;
	sapi_pkg::rx_state_t  state_nxt;
	logic                 res_valid;
	sapi_pkg::rx_result_t res;
	logic                 out_valid_s2;
	sapi_pkg::rx_result_t res_s2;
	logic                 out_free;
	logic                 advance_s1;

	assign out_free   = !out_valid_s2 || out_ready;
	assign advance_s1 = valid_s1 && out_free;
	assign in_ready   = !valid_s1 || out_free;

	// Length limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= sapi_pkg::MAX_LEN_RESET;
		end else if (cfg_we) begin
			max_len_q <= cfg_wdata;
		end
	end

	// Input stage: capture the transaction when it is accepted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1   <= op;
			byte_s1 <= rx_byte;
		end
	end

	sapi_decode u_decode (
		.cur       (state_q),
		.op        (op_s1),
		.rx_byte   (byte_s1),
		.max_len   (max_len_q),
		.nxt       (state_nxt),
		.res_valid (res_valid),
		.res       (res)
	);

	// Frame state: advance when the input stage hands its item on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sapi_pkg::STATE_RESET;
		end else if (advance_s1) begin
			state_q <= state_nxt;
		end
	end

	// Result register: load on advance, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (out_free) begin
			out_valid_s2 <= advance_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && res_valid) begin
			res_s2 <= res;
		end
	end

	assign out_valid = out_valid_s2;
	assign status    = res_s2.status;
	assign data      = res_s2.data;
	assign index     = res_s2.index;
	assign frame_len = res_s2.frame_len;
	assign ack_seen  = res_s2.ack_seen;
	assign send_ack  = res_s2.send_ack;

endmodule
